// ===== rtl/core/lprl_pkg.sv =====
// Shared types, widths and helper functions for the longest-prefix route lookup core.
// Depends on nothing; the cell and the top level take names from it by scope.
package lprl_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = 32;
   localparam int PORT_W      = 8;
   localparam int INDEX_W     = 8;
   localparam int COUNT_W     = 9;
   localparam int LEN_W       = $clog2(ADDR_W + 1);

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // One stored route. The mask length is worked out when the entry is written.
   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } entry_type;

   // Search token that walks down the row of cells, carrying the best match so far.
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] remain;
      logic               found;
      logic [LEN_W-1:0]   len;
      logic [ADDR_W-1:0]  hop;
      logic [PORT_W-1:0]  port;
   } token_type;

   // Population count done per byte, then the four byte counts are summed.
   function automatic logic [LEN_W-1:0] ones_count(input logic [ADDR_W-1:0] v);
      logic [3:0]       byte_cnt;
      logic [LEN_W-1:0] total;
      total = '0;
      for (int b = 0; b < ADDR_W / 8; b++) begin
         byte_cnt = '0;
         for (int k = 0; k < 8; k++) begin
            byte_cnt = byte_cnt + 4'(v[8*b+k]);
         end
         total = total + LEN_W'(byte_cnt);
      end
      return total;
   endfunction

endpackage

// ===== rtl/core/lprl_cell.sv =====
// One cell of the lookup row: holds a single route and compares it against the
// passing search token. Depends on lprl_pkg.
module lprl_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lprl_pkg::ADDR_W-1:0] dest_ip,
   input  logic                       wr_sel,
   input  lprl_pkg::entry_type        wr_entry,
   input  lprl_pkg::token_type        tok_in,
   output lprl_pkg::token_type        tok_out
);

   lprl_pkg::entry_type entry_ff;
   lprl_pkg::entry_type entry_in;
   lprl_pkg::token_type tok_ff;
   lprl_pkg::token_type tok_in_next;
   logic                in_range;
   logic                hit;
   logic                take;

   always_comb begin
      entry_in = wr_sel ? wr_entry : entry_ff;

      // The token only looks at this cell while it still has entries left to cover.
      in_range = (tok_in.remain != '0);
      hit      = in_range && ((dest_ip & entry_ff.mask) == entry_ff.prefix);
      // A strictly longer mask is needed to win, so the lower index keeps ties.
      take     = hit && (!tok_in.found || (entry_ff.len > tok_in.len));

      tok_in_next = tok_in;
      if (in_range) begin
         tok_in_next.remain = tok_in.remain - lprl_pkg::COUNT_W'(1);
      end
      if (take) begin
         tok_in_next.found = 1'b1;
         tok_in_next.len   = entry_ff.len;
         tok_in_next.hop   = entry_ff.hop;
         tok_in_next.port  = entry_ff.port;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/core/longest_prefix_route_lookup_core.sv =====
// Longest-prefix IPv4 route lookup: a row of TABLE_DEPTH cells that each hold one route.
// Lookup: the request transfer registers a search token that steps one cell per cycle; at
// the row's end its result goes to the hold register, then to the response register once
// that is free. The next request is taken only after that move, which waits while the result
// register holds an unaccepted result; table writes are taken one per cycle while idle.
// Reset clears control state, entry count and tokens. Depends on lprl_pkg and lprl_cell.
module longest_prefix_route_lookup_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_req_type,
   input  logic [lprl_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [lprl_pkg::ADDR_W-1:0]   req_entry_prefix,
   input  logic [lprl_pkg::ADDR_W-1:0]   req_entry_mask,
   input  logic [lprl_pkg::ADDR_W-1:0]   req_entry_hop_addr,
   input  logic [lprl_pkg::PORT_W-1:0]   req_entry_port,
   input  logic [lprl_pkg::ADDR_W-1:0]   req_dest_ip,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_route_found,
   output logic [lprl_pkg::ADDR_W-1:0]   rsp_hop_addr,
   output logic [lprl_pkg::PORT_W-1:0]   rsp_out_port,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lprl_pkg::COUNT_W-1:0]  csr_entry_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DELIVER
   } state_type;

   state_type                      state_ff, state_in;
   logic [lprl_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [lprl_pkg::ADDR_W-1:0]    dest_ff, dest_in;
   lprl_pkg::token_type            inj_ff, inj_in;
   lprl_pkg::token_type            hold_ff, hold_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [lprl_pkg::ADDR_W-1:0]    rsp_hop_ff, rsp_hop_in;
   logic [lprl_pkg::PORT_W-1:0]    rsp_port_ff, rsp_port_in;

   logic                           req_fire;
   logic                           wr_fire;
   logic                           lookup_fire;
   logic                           rsp_free;
   logic [lprl_pkg::COUNT_W-1:0]   limit;
   lprl_pkg::entry_type            wr_entry;
   lprl_pkg::token_type            tok [lprl_pkg::TABLE_DEPTH+1];
   logic [lprl_pkg::TABLE_DEPTH:0] tok_valid;
   logic [lprl_pkg::TABLE_DEPTH-1:0] wr_sel;

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign req_fire    = req_valid && req_ready;
   assign wr_fire     = req_fire && (req_req_type == lprl_pkg::REQ_WRITE);
   assign lookup_fire = req_fire && (req_req_type == lprl_pkg::REQ_LOOKUP);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   // Counts above the table depth search the whole table.
   assign limit = (int'(count_ff) > lprl_pkg::TABLE_DEPTH) ?
                  lprl_pkg::COUNT_W'(lprl_pkg::TABLE_DEPTH) : count_ff;

   always_comb begin
      wr_entry.prefix = req_entry_prefix;
      wr_entry.mask   = req_entry_mask;
      wr_entry.len    = lprl_pkg::ones_count(req_entry_mask);
      wr_entry.hop    = req_entry_hop_addr;
      wr_entry.port   = req_entry_port;
   end

   assign tok[0] = inj_ff;

   for (genvar gi = 0; gi < lprl_pkg::TABLE_DEPTH; gi++) begin : g_row
      assign wr_sel[gi] = wr_fire && (int'(req_entry_index) == gi);

      lprl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .dest_ip  (dest_ff),
         .wr_sel   (wr_sel[gi]),
         .wr_entry (wr_entry),
         .tok_in   (tok[gi]),
         .tok_out  (tok[gi+1])
      );
   end

   for (genvar gv = 0; gv <= lprl_pkg::TABLE_DEPTH; gv++) begin : g_valid
      assign tok_valid[gv] = tok[gv].valid;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_valid ? csr_entry_count : count_ff;
      dest_in      = lookup_fire ? req_dest_ip : dest_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_hop_in   = rsp_hop_ff;
      rsp_port_in  = rsp_port_ff;

      inj_in        = '0;
      inj_in.valid  = lookup_fire;
      inj_in.remain = limit;

      case (state_ff)
         ST_IDLE: begin
            if (lookup_fire) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok[lprl_pkg::TABLE_DEPTH].valid) begin
               hold_in  = tok[lprl_pkg::TABLE_DEPTH];
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hold_ff.found;
               rsp_hop_in   = hold_ff.hop;
               rsp_port_in  = hold_ff.port;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dest_ff     <= dest_in;
      hold_ff     <= hold_in;
      rsp_found_ff <= rsp_found_in;
      rsp_hop_ff  <= rsp_hop_in;
      rsp_port_ff <= rsp_port_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         inj_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         inj_ff       <= inj_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_route_found = rsp_found_ff;
   assign rsp_hop_addr    = rsp_hop_ff;
   assign rsp_out_port    = rsp_port_ff;

   // Only one search token may be in the row at any time.
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid) <= 1)
      else $error("more than one search token in the cell row");

   // A token leaves the row only while a search is in progress.
   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      tok[lprl_pkg::TABLE_DEPTH].valid |-> state_ff == ST_SEARCH)
      else $error("search token left the row outside a search");

   // A freshly injected token always belongs to a running search.
   a_inject_in_search: assert property (@(posedge clock) disable iff (reset)
      inj_ff.valid |-> state_ff == ST_SEARCH)
      else $error("token injected without a search in progress");

   // A miss reports zero next hop and zero port.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_hop_ff == '0 && rsp_port_ff == '0)
      else $error("miss response carries nonzero route data");

endmodule
